>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define U8_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define U8_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define U8_ASSERT(lbl, clk, rst, prop)
`define U8_NEVER(lbl, clk, rst, expr)
`endif

`endif

>>> hw/rtl/u8u16_pkg.sv
// Types, constants and byte classification for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

   localparam int UNIT_COUNT_BITS = 16;
   localparam int MAX_UNITS_BITS  = 16;
   localparam int CMP_BITS        =
      ((UNIT_COUNT_BITS > MAX_UNITS_BITS) ? UNIT_COUNT_BITS : MAX_UNITS_BITS) + 2;
   localparam int CP_BITS         = 21;
   localparam int ADDR_BITS       = 3;
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   localparam logic [MAX_UNITS_BITS-1:0] MAX_UNITS_RESET = 16'd64;
   localparam logic                      REG_MAX_UNITS   = 1'b0;

   localparam logic [15:0]        QMARK_UNIT = 16'h003F;
   localparam logic [15:0]        SURR_HI    = 16'hD800;
   localparam logic [15:0]        SURR_LO    = 16'hDC00;
   localparam logic [CP_BITS-1:0] SUPP_BASE  = 21'h10000;

   typedef enum logic [1:0] {
      SEQ_LEN1 = 2'd0,
      SEQ_LEN2 = 2'd1,
      SEQ_LEN3 = 2'd2,
      SEQ_LEN4 = 2'd3
   } seq_len_type;

   typedef struct packed {
      logic        is_zero;
      logic        is_cont;
      logic        is_ascii;
      seq_len_type len;
      logic [4:0]  lead_bits;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data;
      byte_class_type cls;
   } byte_entry_type;

   typedef struct packed {
      logic           valid;
      byte_entry_type entry;
   } head_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      c.is_zero  = (b == 8'h00);
      c.is_cont  = (b[7:6] == 2'b10);
      c.is_ascii = (b[7] == 1'b0);
      if (b inside {[8'h00:8'h7F]}) begin
         c.len       = SEQ_LEN1;
         c.lead_bits = b[4:0];
      end else if (b inside {[8'h80:8'hDF]}) begin
         c.len       = SEQ_LEN2;
         c.lead_bits = b[4:0];
      end else if (b inside {[8'hE0:8'hEF]}) begin
         c.len       = SEQ_LEN3;
         c.lead_bits = {1'b0, b[3:0]};
      end else begin
         c.len       = SEQ_LEN4;
         c.lead_bits = {2'b00, b[2:0]};
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/u8u16_front.sv
// Front end: takes input beats, classifies each byte and queues it for the back end.
module u8u16_front
   import u8u16_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output head_type   head,
   input  logic       pop
);

   byte_entry_type            q_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                      push;
   byte_entry_type            push_entry;

   assign req_stall        = (cnt_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign push             = req_valid && !req_stall;
   assign push_entry.data  = req_in_byte;
   assign push_entry.cls   = classify(req_in_byte);
   assign head.valid       = (cnt_ff != '0);
   assign head.entry       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + FIFO_CNT_BITS'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

`include "assert_macros.svh"

   `U8_NEVER(a_fifo_bound, clock, reset, cnt_ff > FIFO_CNT_BITS'(FIFO_DEPTH))
   `U8_NEVER(a_pop_empty, clock, reset, pop && (cnt_ff == '0))
   `U8_NEVER(a_ptr_gap, clock, reset, FIFO_PTR_BITS'(wr_ptr_ff - rd_ptr_ff) != cnt_ff[FIFO_PTR_BITS-1:0])

endmodule

>>> hw/rtl/u8u16_back.sv
// Back end: sequence assembly, replay after bad continuations, capacity and output register.
module u8u16_back
   import u8u16_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  head_type                  head,
   output logic                      pop,
   input  logic [MAX_UNITS_BITS-1:0] max_units,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_code_unit,
   output logic                      rsp_is_last
);

   // output register and held low surrogate
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [15:0]                code_ff, code_in;
   logic                       last_ff, last_in;
   logic                       lo_pend_ff, lo_pend_in;
   logic [15:0]                lo_unit_ff, lo_unit_in;
   // sequence state
   logic [1:0]                 pend_cnt_ff, pend_cnt_in;
   seq_len_type                lead_len_ff, lead_len_in;
   logic [4:0]                 lead_bits_ff, lead_bits_in;
   logic [7:0]                 pend1_ff, pend1_in;
   logic [7:0]                 pend2_ff, pend2_in;
   logic [UNIT_COUNT_BITS-1:0] uw_ff, uw_in;
   logic                       stopped_ff, stopped_in;
   // replay buffer
   logic [7:0]                 rep_ff [3];
   logic [7:0]                 rep_in [3];
   logic [1:0]                 rep_cnt_ff, rep_cnt_in;

   logic                       out_free;
   logic                       from_rep;
   logic                       src_valid;
   logic                       step;
   logic [7:0]                 b;
   byte_class_type             bc;
   logic [1:0]                 rest_cnt;
   logic [CMP_BITS-1:0]        uw_p1, uw_p2, max_ext;
   logic                       no_room1, no_room2;
   logic [CP_BITS-1:0]         cp, cpm;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign from_rep  = (rep_cnt_ff != 2'd0);
   assign src_valid = from_rep || head.valid;
   assign step      = out_free && !lo_pend_ff && src_valid;
   assign pop       = step && !from_rep;
   assign b         = from_rep ? rep_ff[0] : head.entry.data;
   assign bc        = from_rep ? classify(rep_ff[0]) : head.entry.cls;
   assign rest_cnt  = from_rep ? rep_cnt_ff - 2'd1 : 2'd0;

   assign max_ext  = CMP_BITS'(max_units);
   assign uw_p1    = CMP_BITS'(uw_ff) + CMP_BITS'(1);
   assign uw_p2    = CMP_BITS'(uw_ff) + CMP_BITS'(2);
   assign no_room1 = (uw_p1 >= max_ext);
   assign no_room2 = (uw_p2 >= max_ext);

   always_comb begin
      case (pend_cnt_ff)
         2'd1:    cp = CP_BITS'({lead_bits_ff, b[5:0]});
         2'd2:    cp = CP_BITS'({lead_bits_ff, pend1_ff[5:0], b[5:0]});
         2'd3:    cp = CP_BITS'({lead_bits_ff, pend1_ff[5:0], pend2_ff[5:0], b[5:0]});
         default: cp = '0;
      endcase
      cpm = cp - SUPP_BASE;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      code_in      = code_ff;
      last_in      = last_ff;
      lo_pend_in   = lo_pend_ff;
      lo_unit_in   = lo_unit_ff;
      pend_cnt_in  = pend_cnt_ff;
      lead_len_in  = lead_len_ff;
      lead_bits_in = lead_bits_ff;
      pend1_in     = pend1_ff;
      pend2_in     = pend2_ff;
      uw_in        = uw_ff;
      stopped_in   = stopped_ff;
      rep_in       = rep_ff;
      rep_cnt_in   = rep_cnt_ff;

      if (out_free && lo_pend_ff) begin
         rsp_valid_in = 1'b1;
         code_in      = lo_unit_ff;
         last_in      = 1'b0;
         lo_pend_in   = 1'b0;
      end

      if (step) begin
         if (from_rep) begin
            rep_in[0]  = rep_ff[1];
            rep_in[1]  = rep_ff[2];
            rep_cnt_in = rep_cnt_ff - 2'd1;
         end
         if (stopped_ff) begin
            if (bc.is_zero) begin
               stopped_in  = 1'b0;
               uw_in       = '0;
               pend_cnt_in = 2'd0;
            end
         end else if (pend_cnt_ff == 2'd0) begin
            if (bc.is_zero) begin
               rsp_valid_in = 1'b1;
               code_in      = '0;
               last_in      = 1'b1;
               uw_in        = '0;
            end else if (no_room1) begin
               rsp_valid_in = 1'b1;
               code_in      = '0;
               last_in      = 1'b1;
               stopped_in   = 1'b1;
            end else if (bc.is_ascii) begin
               rsp_valid_in = 1'b1;
               code_in      = {8'h00, b};
               last_in      = 1'b0;
               uw_in        = uw_ff + UNIT_COUNT_BITS'(1);
            end else begin
               lead_len_in  = bc.len;
               lead_bits_in = bc.lead_bits;
               pend_cnt_in  = 2'd1;
            end
         end else if (!bc.is_cont) begin
            // bad continuation: '?' for the lead, the rest goes round again
            rsp_valid_in = 1'b1;
            code_in      = QMARK_UNIT;
            last_in      = 1'b0;
            uw_in        = uw_ff + UNIT_COUNT_BITS'(1);
            pend_cnt_in  = 2'd0;
            rep_cnt_in   = pend_cnt_ff + rest_cnt;
            case (pend_cnt_ff)
               2'd1: begin
                  rep_in[0] = b;
                  rep_in[1] = rep_ff[1];
                  rep_in[2] = rep_ff[2];
               end
               2'd2: begin
                  rep_in[0] = pend1_ff;
                  rep_in[1] = b;
                  rep_in[2] = rep_ff[1];
               end
               2'd3: begin
                  rep_in[0] = pend1_ff;
                  rep_in[1] = pend2_ff;
                  rep_in[2] = b;
               end
               default: begin
                  rep_in = rep_ff;
               end
            endcase
         end else if (pend_cnt_ff < 2'(lead_len_ff)) begin
            if (pend_cnt_ff == 2'd1) begin
               pend1_in = b;
            end else begin
               pend2_in = b;
            end
            pend_cnt_in = pend_cnt_ff + 2'd1;
         end else begin
            pend_cnt_in = 2'd0;
            if (cp[CP_BITS-1:16] == '0) begin
               rsp_valid_in = 1'b1;
               code_in      = cp[15:0];
               last_in      = 1'b0;
               uw_in        = uw_ff + UNIT_COUNT_BITS'(1);
            end else if (no_room2) begin
               rsp_valid_in = 1'b1;
               code_in      = '0;
               last_in      = 1'b1;
               stopped_in   = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               code_in      = SURR_HI | 16'(cpm >> 10);
               last_in      = 1'b0;
               lo_pend_in   = 1'b1;
               lo_unit_in   = SURR_LO | {6'd0, cpm[9:0]};
               uw_in        = uw_ff + UNIT_COUNT_BITS'(2);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         lo_pend_ff   <= 1'b0;
         pend_cnt_ff  <= 2'd0;
         uw_ff        <= '0;
         stopped_ff   <= 1'b0;
         rep_cnt_ff   <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         lo_pend_ff   <= lo_pend_in;
         pend_cnt_ff  <= pend_cnt_in;
         uw_ff        <= uw_in;
         stopped_ff   <= stopped_in;
         rep_cnt_ff   <= rep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      last_ff      <= last_in;
      lo_unit_ff   <= lo_unit_in;
      lead_len_ff  <= lead_len_in;
      lead_bits_ff <= lead_bits_in;
      pend1_ff     <= pend1_in;
      pend2_ff     <= pend2_in;
      rep_ff       <= rep_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_unit = code_ff;
   assign rsp_is_last   = last_ff;

`include "assert_macros.svh"

   `U8_ASSERT(a_lo_behind_hi, clock, reset, lo_pend_ff |-> rsp_valid_ff)
   `U8_NEVER(a_bytes_bound, clock, reset, (3'(pend_cnt_ff) + 3'(rep_cnt_ff)) > 3'd3)
   `U8_ASSERT(a_last_is_zero, clock, reset, (rsp_valid_ff && last_ff) |-> (code_ff == '0))
   `U8_ASSERT(a_stop_no_seq, clock, reset, stopped_ff |-> (pend_cnt_ff == 2'd0))

endmodule

>>> hw/rtl/utf8_to_utf16_transcoder_core.sv
// Top level of the UTF-8 to UTF-16 transcoder: register port, front end and back end.
//
//   port  | direction | beat
//   ------+-----------+------------------------------------------------
//   req   | in        | one UTF-8 byte; a zero byte ends the string
//   rsp   | out       | one UTF-16 code unit, is_last on the terminator
//   csr   | in/out    | APB-style, max_units at byte address 0
//
// The back end handles one byte a cycle unless rsp stalls or a low surrogate is still
// to be sent; bytes replayed after a bad continuation go through it again.
// A 4-entry queue lets the front end take beats while the back end stalls.
// Synchronous reset; max_units comes back as 64. No clearing pass.
// req_stall rises only when the queue is full; rsp holds while rsp_stall is high.
module utf8_to_utf16_transcoder_core
   import u8u16_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_code_unit,
   output logic                 rsp_is_last,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic [MAX_UNITS_BITS-1:0] max_units_ff, max_units_in;
   logic                      reg_wr;
   head_type                  head;
   logic                      pop;

   assign pready = 1'b1;
   assign reg_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_MAX_UNITS) ? 32'(max_units_ff) : '0;

   always_comb begin
      max_units_in = max_units_ff;
      if (reg_wr && (paddr[2] == REG_MAX_UNITS)) begin
         max_units_in = pwdata[MAX_UNITS_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= MAX_UNITS_RESET;
      end else begin
         max_units_ff <= max_units_in;
      end
   end

   u8u16_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .head        (head),
      .pop         (pop)
   );

   u8u16_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .max_units     (max_units_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_unit (rsp_code_unit),
      .rsp_is_last   (rsp_is_last)
   );

endmodule
